[sv/idc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package idc_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH_DEF  = 2;
  localparam int unsigned IO_W             = 32;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned CFG_DATA_W       = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HP_ALPHA    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LP_ALPHA    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FACTOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEVEL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONV_BITS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_SCALE = 3'd6;

  typedef struct packed {
    logic [1:0]         filter_mode;
    logic [15:0]        hp_alpha;
    logic [15:0]        lp_alpha;
    logic signed [23:0] gain_factor;
    logic [30:0]        clip_level;
    logic [5:0]         conv_bits;
    logic [31:0]        quant_scale;
  } idc_cfg_t;

  localparam idc_cfg_t CFG_RESET = '{
    filter_mode: 2'd0,
    hp_alpha:    16'd0,
    lp_alpha:    16'd0,
    gain_factor: 24'sd65536,
    clip_level:  31'd0,
    conv_bits:   6'd0,
    quant_scale: 32'd0
  };

  typedef struct packed {
    logic hp_en;
    logic lp_en;
    logic clip_en;
    logic q_en;
    logic first;
  } idc_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HP_MUL,
    ST_HP_RND,
    ST_LP_MUL,
    ST_LP_RND,
    ST_LP_ADD,
    ST_GAIN_MUL,
    ST_GAIN_RND,
    ST_CLIP,
    ST_Q_MUL,
    ST_Q_RND
  } idc_state_t;

endpackage
`default_nettype wire

[sv/idc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module idc_front #(
  parameter int unsigned SAMPLE_WIDTH = idc_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire idc_pkg::idc_cfg_t              cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [idc_pkg::IO_W-1:0] in_sample_in,
  input  wire logic                           in_first_of_trace,
  output logic                                push_valid,
  input  wire logic                           push_ready,
  output idc_pkg::idc_ctl_t                   push_ctl,
  output logic signed [SAMPLE_WIDTH-1:0]      push_sample
);

  localparam int unsigned W  = SAMPLE_WIDTH;
  localparam int unsigned SW = W + 32;
  localparam logic signed [W-1:0]  SMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  SMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [SW-1:0] SMAX_X = SW'(SMAX);
  localparam logic signed [SW-1:0] SMIN_X = SW'(SMIN);

  logic                  valid_r, valid_nxt;
  logic signed [W-1:0]   sample_r, sample_nxt;
  idc_pkg::idc_ctl_t     ctl_r, ctl_nxt;
  logic signed [SW-1:0]  in_x;
  logic                  in_xfer;

  assign in_ready = !valid_r || push_ready;
  assign in_xfer  = in_valid && in_ready;
  assign in_x     = SW'(in_sample_in);

  always_comb begin
    if (in_x > SMAX_X) begin
      sample_nxt = SMAX;
    end else if (in_x < SMIN_X) begin
      sample_nxt = SMIN;
    end else begin
      sample_nxt = W'(in_x);
    end
    ctl_nxt.hp_en   = cfg.filter_mode[0];
    ctl_nxt.lp_en   = cfg.filter_mode[1];
    ctl_nxt.clip_en = cfg.clip_level != '0;
    ctl_nxt.q_en    = (cfg.conv_bits != '0) && (cfg.quant_scale != '0);
    ctl_nxt.first   = in_first_of_trace;
  end

  always_comb begin
    if (in_xfer) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_r <= sample_nxt;
      ctl_r    <= ctl_nxt;
    end
  end

  assign push_valid  = valid_r;
  assign push_ctl    = ctl_r;
  assign push_sample = sample_r;

endmodule
`default_nettype wire

[sv/idc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module idc_queue #(
  parameter int unsigned SAMPLE_WIDTH = idc_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned DEPTH        = idc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push_valid,
  output logic                                push_ready,
  input  wire idc_pkg::idc_ctl_t              push_ctl,
  input  wire logic signed [SAMPLE_WIDTH-1:0] push_sample,
  output logic                                pop_valid,
  input  wire logic                           pop_ready,
  output idc_pkg::idc_ctl_t                   pop_ctl,
  output logic signed [SAMPLE_WIDTH-1:0]      pop_sample
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  idc_pkg::idc_ctl_t              ctl_mem_r [DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] smp_mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = count_r != CNT_FULL;
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_ctl    = ctl_mem_r[rd_ptr_r];
  assign pop_sample = smp_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem_r[wr_ptr_r] <= push_ctl;
      smp_mem_r[wr_ptr_r] <= push_sample;
    end
  end

endmodule
`default_nettype wire

[sv/idc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module idc_back #(
  parameter int unsigned SAMPLE_WIDTH = idc_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire idc_pkg::idc_cfg_t              cfg,
  input  wire logic                           q_valid,
  output logic                                q_ready,
  input  wire idc_pkg::idc_ctl_t              q_ctl,
  input  wire logic signed [SAMPLE_WIDTH-1:0] q_sample,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [idc_pkg::IO_W-1:0]     out_sample_out
);

  localparam int unsigned W   = SAMPLE_WIDTH;
  localparam int unsigned PW  = W + 24;
  localparam int unsigned RW  = PW - 16;
  localparam int unsigned CW  = W + 32;
  localparam int unsigned QHW = W - 15;
  localparam int unsigned QPW = QHW + 32;
  localparam int unsigned QSW = W + 33;

  localparam logic signed [W-1:0]   SMAX      = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]   SMIN      = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [PW-1:0]  RND_HALF  = PW'(32768);
  localparam logic signed [PW-1:0]  RND_HALFM = PW'(32767);
  localparam logic signed [CW-1:0]  SMAX_X    = CW'(SMAX);
  localparam logic signed [CW-1:0]  O_MAX     = CW'($signed(32'h7FFF_FFFF));
  localparam logic signed [CW-1:0]  O_MIN     = CW'($signed(32'h8000_0000));
  localparam logic [QSW-1:0]        Q_HALF    = QSW'(64'h8000_0000);

  idc_pkg::idc_state_t state_r, state_nxt;
  idc_pkg::idc_ctl_t   ctl_r, ctl_nxt;
  logic signed [W-1:0]  v_r, v_nxt;
  logic signed [W-1:0]  hp_in_r, hp_in_nxt;
  logic signed [W-1:0]  hp_out_r, hp_out_nxt;
  logic signed [W-1:0]  lp_out_r, lp_out_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic [47:0]          qlo_r, qlo_nxt;
  logic [QPW-1:0]       qhi_r, qhi_nxt;
  logic [30:0]          maxc_r, maxc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [idc_pkg::IO_W-1:0] out_data_r;

  logic out_free, q_pop, out_load;

  // rounding and saturation of the product register
  logic signed [PW-1:0] rnd_sum;
  logic signed [RW-1:0] rnd_q;
  logic signed [W-1:0]  rnd_sat;

  logic signed [W+1:0]  hp_d;
  logic signed [W+18:0] hp_p;
  logic signed [W:0]    lp_e;
  logic signed [W+17:0] lp_p;
  logic signed [W:0]    lp_sum;
  logic signed [W-1:0]  lp_sat;
  logic signed [PW-1:0] gn_p;

  logic signed [CW-1:0] clip_raw, clip_lim, clip_neg, v_x;
  logic [5:0]           adc_b, adc_bm1;

  logic signed [W:0]    q_vx;
  logic [W:0]           q_mag;
  logic [QSW-1:0]       q_sum, q_full, q_maxx, q_m;
  logic [31:0]          q_m32;
  logic signed [idc_pkg::IO_W-1:0] q_res, o_res, res;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    rnd_sum = prod_r + (prod_r[PW-1] ? RND_HALFM : RND_HALF);
    rnd_q   = RW'(rnd_sum >>> 16);
    if (rnd_q > RW'(SMAX)) begin
      rnd_sat = SMAX;
    end else if (rnd_q < RW'(SMIN)) begin
      rnd_sat = SMIN;
    end else begin
      rnd_sat = W'(rnd_q);
    end
  end

  always_comb begin
    hp_d   = (W+2)'(hp_out_r) + (W+2)'(v_r) - (W+2)'(hp_in_r);
    hp_p   = hp_d * $signed({1'b0, cfg.hp_alpha});
    lp_e   = (W+1)'(v_r) - (W+1)'(lp_out_r);
    lp_p   = lp_e * $signed({1'b0, cfg.lp_alpha});
    gn_p   = v_r * cfg.gain_factor;
    lp_sum = (W+1)'(lp_out_r) + (W+1)'(v_r);
    if (lp_sum > (W+1)'(SMAX)) begin
      lp_sat = SMAX;
    end else if (lp_sum < (W+1)'(SMIN)) begin
      lp_sat = SMIN;
    end else begin
      lp_sat = W'(lp_sum);
    end
  end

  always_comb begin
    clip_raw = {{(CW-31){1'b0}}, cfg.clip_level};
    clip_lim = (clip_raw > SMAX_X) ? SMAX_X : clip_raw;
    clip_neg = -clip_lim;
    v_x      = CW'(v_r);
    adc_b    = (cfg.conv_bits > 6'd32) ? 6'd32 : cfg.conv_bits;
    adc_bm1  = adc_b - 6'd1;
    maxc_nxt = 31'((32'd1 << adc_bm1) - 32'd1);
  end

  always_comb begin
    q_vx   = (W+1)'(v_r);
    q_mag  = v_r[W-1] ? (-q_vx) : q_vx;
    q_sum  = (QSW'(qhi_r) << 16) + QSW'(qlo_r) + Q_HALF;
    q_full = q_sum >> 32;
    q_maxx = QSW'(maxc_r);
    q_m    = (q_full > q_maxx) ? q_maxx : q_full;
    q_m32  = q_m[31:0];
    q_res  = v_r[W-1] ? $signed(-q_m32) : $signed(q_m32);
    if (v_x > O_MAX) begin
      o_res = 32'sh7FFF_FFFF;
    end else if (v_x < O_MIN) begin
      o_res = $signed(32'h8000_0000);
    end else begin
      o_res = 32'(v_x);
    end
    res = ctl_r.q_en ? q_res : o_res;
  end

  // next state
  always_comb begin
    unique case (state_r)
      idc_pkg::ST_IDLE:     state_nxt = q_valid ? idc_pkg::ST_HP_MUL : idc_pkg::ST_IDLE;
      idc_pkg::ST_HP_MUL:   state_nxt = idc_pkg::ST_HP_RND;
      idc_pkg::ST_HP_RND:   state_nxt = idc_pkg::ST_LP_MUL;
      idc_pkg::ST_LP_MUL:   state_nxt = idc_pkg::ST_LP_RND;
      idc_pkg::ST_LP_RND:   state_nxt = idc_pkg::ST_LP_ADD;
      idc_pkg::ST_LP_ADD:   state_nxt = idc_pkg::ST_GAIN_MUL;
      idc_pkg::ST_GAIN_MUL: state_nxt = idc_pkg::ST_GAIN_RND;
      idc_pkg::ST_GAIN_RND: state_nxt = idc_pkg::ST_CLIP;
      idc_pkg::ST_CLIP:     state_nxt = idc_pkg::ST_Q_MUL;
      idc_pkg::ST_Q_MUL:    state_nxt = idc_pkg::ST_Q_RND;
      idc_pkg::ST_Q_RND:    state_nxt = out_free ? idc_pkg::ST_IDLE : idc_pkg::ST_Q_RND;
      default:              state_nxt = idc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop    = (state_r == idc_pkg::ST_IDLE) && q_valid;
    out_load = (state_r == idc_pkg::ST_Q_RND) && out_free;
  end

  assign q_ready = q_pop;

  // datapath
  always_comb begin
    ctl_nxt    = ctl_r;
    v_nxt      = v_r;
    hp_in_nxt  = hp_in_r;
    hp_out_nxt = hp_out_r;
    lp_out_nxt = lp_out_r;
    prod_nxt   = prod_r;
    qlo_nxt    = qlo_r;
    qhi_nxt    = qhi_r;
    unique case (state_r)
      idc_pkg::ST_IDLE: begin
        if (q_pop) begin
          ctl_nxt = q_ctl;
          v_nxt   = q_sample;
        end
      end
      idc_pkg::ST_HP_MUL: begin
        if (ctl_r.hp_en) begin
          hp_in_nxt = v_r;
          if (ctl_r.first) begin
            hp_out_nxt = '0;
            v_nxt      = '0;
          end else begin
            prod_nxt = PW'(hp_p);
          end
        end
      end
      idc_pkg::ST_HP_RND: begin
        if (ctl_r.hp_en && !ctl_r.first) begin
          hp_out_nxt = rnd_sat;
          v_nxt      = rnd_sat;
        end
      end
      idc_pkg::ST_LP_MUL: begin
        if (ctl_r.lp_en) begin
          if (ctl_r.first) begin
            lp_out_nxt = v_r;
          end else begin
            prod_nxt = PW'(lp_p);
          end
        end
      end
      idc_pkg::ST_LP_RND: begin
        if (ctl_r.lp_en && !ctl_r.first) begin
          v_nxt = rnd_sat;
        end
      end
      idc_pkg::ST_LP_ADD: begin
        if (ctl_r.lp_en && !ctl_r.first) begin
          lp_out_nxt = lp_sat;
          v_nxt      = lp_sat;
        end
      end
      idc_pkg::ST_GAIN_MUL: begin
        prod_nxt = gn_p;
      end
      idc_pkg::ST_GAIN_RND: begin
        v_nxt = rnd_sat;
      end
      idc_pkg::ST_CLIP: begin
        if (ctl_r.clip_en) begin
          if (v_x > clip_lim) begin
            v_nxt = W'(clip_lim);
          end else if (v_x < clip_neg) begin
            v_nxt = W'(clip_neg);
          end
        end
      end
      idc_pkg::ST_Q_MUL: begin
        qlo_nxt = q_mag[15:0] * cfg.quant_scale;
        qhi_nxt = q_mag[W:16] * cfg.quant_scale;
      end
      idc_pkg::ST_Q_RND: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= idc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      hp_in_r     <= '0;
      hp_out_r    <= '0;
      lp_out_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hp_in_r     <= hp_in_nxt;
      hp_out_r    <= hp_out_nxt;
      lp_out_r    <= lp_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r  <= ctl_nxt;
    v_r    <= v_nxt;
    prod_r <= prod_nxt;
    qlo_r  <= qlo_nxt;
    qhi_r  <= qhi_nxt;
    if (state_r == idc_pkg::ST_CLIP) begin
      maxc_r <= maxc_nxt;
    end
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

endmodule
`default_nettype wire

[sv/instrument_digitizer_chain.sv]
`timescale 1ns / 1ps
`default_nettype none
// seismometer recording chain: each Q16.16 sample passes an optional RC high-pass and
// low-pass, a Q8.16 gain, an optional symmetric clip and an optional ADC quantizer to
// counts. the back-end sequencer sets the pace: it steps the filter recursions, gain, clip
// and quantizer through its multipliers one stage per cycle while no result waits on
// out_ready, and takes a new sample only when idle. an input register and a queue (two
// entries by default) let new samples transfer in while the back end works or while a
// result waits on out_ready, and each result leaves through an output register.
// configuration writes take effect at once and must only be made while the chain is empty.
module instrument_digitizer_chain #(
  parameter int unsigned SAMPLE_WIDTH = idc_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH  = idc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [idc_pkg::IO_W-1:0]      in_sample_in,
  input  wire logic                                 in_first_of_trace,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [idc_pkg::IO_W-1:0]           out_sample_out,
  input  wire logic                                 cfg_we,
  input  wire logic [idc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [idc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  idc_pkg::idc_cfg_t cfg_r, cfg_nxt;

  logic                           push_valid, push_ready;
  idc_pkg::idc_ctl_t              push_ctl;
  logic signed [SAMPLE_WIDTH-1:0] push_sample;
  logic                           pop_valid, pop_ready;
  idc_pkg::idc_ctl_t              pop_ctl;
  logic signed [SAMPLE_WIDTH-1:0] pop_sample;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        idc_pkg::REG_FILTER_MODE: cfg_nxt.filter_mode = cfg_wdata[1:0];
        idc_pkg::REG_HP_ALPHA:    cfg_nxt.hp_alpha    = cfg_wdata[15:0];
        idc_pkg::REG_LP_ALPHA:    cfg_nxt.lp_alpha    = cfg_wdata[15:0];
        idc_pkg::REG_GAIN_FACTOR: cfg_nxt.gain_factor = $signed(cfg_wdata[23:0]);
        idc_pkg::REG_CLIP_LEVEL:  cfg_nxt.clip_level  = cfg_wdata[30:0];
        idc_pkg::REG_CONV_BITS:   cfg_nxt.conv_bits   = cfg_wdata[5:0];
        idc_pkg::REG_QUANT_SCALE: cfg_nxt.quant_scale = cfg_wdata[31:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= idc_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  idc_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_in     (in_sample_in),
    .in_first_of_trace(in_first_of_trace),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_ctl         (push_ctl),
    .push_sample      (push_sample)
  );

  idc_queue #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .DEPTH       (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_ctl   (push_ctl),
    .push_sample(push_sample),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_ctl    (pop_ctl),
    .pop_sample (pop_sample)
  );

  idc_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (pop_valid),
    .q_ready       (pop_ready),
    .q_ctl         (pop_ctl),
    .q_sample      (pop_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out)
  );

endmodule
`default_nettype wire

[sv/idc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module idc_checker #(
  parameter int unsigned QUEUE_DEPTH = idc_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic signed [idc_pkg::IO_W-1:0] out_sample_out
);

  // input register, back end and output register each hold one sample, the queue QUEUE_DEPTH
  localparam int unsigned PEND_MAX = QUEUE_DEPTH + 3;
  localparam int unsigned PEND_W   = $clog2(PEND_MAX + 1);

  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + PEND_W'(1);
    end else if (out_xfer && !in_xfer) begin
      pend_nxt = pend_r - PEND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out))
    else $error("result changed or dropped while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result offered with no sample outstanding");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == PEND_W'(PEND_MAX) |-> !in_ready)
    else $error("input ready while every stage is occupied");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind instrument_digitizer_chain idc_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_idc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_sample_out(out_sample_out)
);
`default_nettype wire
